// ===== rtl/frame_rate_monitor_adaptive_quality_top_assert.svh =====
// Assertion macros for the frame rate monitor top level.
`ifndef FRAME_RATE_MONITOR_ADAPTIVE_QUALITY_TOP_ASSERT_SVH
`define FRAME_RATE_MONITOR_ADAPTIVE_QUALITY_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset
`define FRMAQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frmaq: same-cycle check failed");

// Next-cycle implication, held off during reset
`define FRMAQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frmaq: next-cycle check failed");

`endif

// ===== rtl/frmaq_pkg.sv =====
// Shared types and constants of the frame rate monitor.
package frmaq_pkg;

   // Field widths
   localparam int FPS_W   = 28;
   localparam int US_W    = 24;
   localparam int QUAL_W  = 17;
   localparam int AVGW_W  = 9;
   localparam int Q_FRAC_W = 16;

   // Fixed part of the result word, history count excluded
   localparam int RSP_FIXED_W = 4 * FPS_W + 1 + QUAL_W + US_W;

   // Frame rate and quality constants
   localparam logic [FPS_W-1:0]  FPS_NUM      = 28'd256000000;
   localparam logic [QUAL_W-1:0] QUALITY_FULL = 17'd65536;
   localparam logic [QUAL_W-1:0] QUALITY_STEP = 17'd655;

   // History depth default
   localparam int HISTORY_DEPTH_DEF = 256;

   // Divider widths: quality dividend is the widest numerator by default
   localparam int DIV_NW_DEF = FPS_W + Q_FRAC_W;
   localparam int DIV_DW_DEF = FPS_W;

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_AW-3:0] {
      REG_MIN_FPS    = 2'd0,
      REG_ADAPTIVE   = 2'd1,
      REG_AVG_WINDOW = 2'd2
   } reg_index_type;

   localparam logic [FPS_W-1:0]  MIN_FPS_RST    = 28'd25600;
   localparam logic              ADAPTIVE_RST   = 1'b1;
   localparam logic [AVGW_W-1:0] AVG_WINDOW_RST = 9'd60;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [FPS_W-1:0]  min_fps;
      logic              adaptive;
      logic [AVGW_W-1:0] avg_window;
   } cfg_type;

   // One history entry
   typedef struct packed {
      logic [US_W-1:0]  us;
      logic [FPS_W-1:0] fps;
   } hist_entry_type;

endpackage

// ===== rtl/frmaq_csr.sv =====
// Configuration registers behind the APB-style port.
module frmaq_csr
   import frmaq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [CSR_AW-3:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign cfg        = cfg_ff;

   // Decode the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MIN_FPS:    cfg_in.min_fps    = csr_pwdata[FPS_W-1:0];
            REG_ADAPTIVE:   cfg_in.adaptive   = csr_pwdata[0];
            REG_AVG_WINDOW: cfg_in.avg_window = csr_pwdata[AVGW_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_MIN_FPS:    csr_prdata = CSR_DW'(cfg_ff.min_fps);
         REG_ADAPTIVE:   csr_prdata = CSR_DW'(cfg_ff.adaptive);
         REG_AVG_WINDOW: csr_prdata = CSR_DW'(cfg_ff.avg_window);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_fps    <= MIN_FPS_RST;
         cfg_ff.adaptive   <= ADAPTIVE_RST;
         cfg_ff.avg_window <= AVG_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/frmaq_hist.sv =====
// History ring memory: one write port, one registered read port.
module frmaq_hist
   import frmaq_pkg::*;
#(
   parameter  int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   localparam int AW = $clog2(HISTORY_DEPTH)
)(
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  hist_entry_type wr_data,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output hist_entry_type rd_data
);

   hist_entry_type mem [HISTORY_DEPTH];
   hist_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   // Store the new entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/frmaq_div.sv =====
// Restoring divider, one quotient bit per cycle.
module frmaq_div
   import frmaq_pkg::*;
#(
   parameter int NW = DIV_NW_DEF,
   parameter int DW = DIV_DW_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Shift in the next dividend bit and try to subtract
   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ===== rtl/frame_rate_monitor_adaptive_quality_top.sv =====
// Frame rate monitor with adaptive quality scale: sequencer and result register.
//
// Each accepted word is one frame duration in microseconds (zero counts as one). The block
// derives fps in Q.8 as floor(256000000/us), flags a drop against min_fps_q8, updates the
// Q1.16 quality scale and stores the frame in a history ring of HISTORY_DEPTH entries held
// in one single-port-read memory. It then reports floor means of fps and frame time over the
// newest min(avg_window, count) entries (a zero window counts as one) and the mean fps over
// all stored entries. A shared one-bit-per-cycle divider, NW bits wide (44 by default), runs
// four times per frame: fps, window fps, window frame time and total fps; a fifth run
// recomputes quality after a drop with adaptive quality on. The window walk reads one ring
// entry per cycle, newest first. The running total over all entries is kept incrementally,
// so besides the oldest entry, read on accept, only the window entries are read back. A
// finished result waits in the output register while the next word is accepted; a result
// still waiting there when the next one is ready holds the sequencer. The ring has no reset
// sweep: the entry count keeps entries not yet written out of the sums.
`include "frame_rate_monitor_adaptive_quality_top_assert.svh"

module frame_rate_monitor_adaptive_quality_top
   import frmaq_pkg::*;
#(
   parameter  int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1),
   localparam int RSP_BITS = RSP_FIXED_W + CNT_W,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
)(
   input  logic              clock,
   input  logic              reset,
   // tdata: frame_us[23:0]
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [US_W-1:0]   req_tdata,
   // tdata from bit 0 up: fps_q8, dropped, drop_amount_q8, quality_q16,
   // window_avg_fps_q8, window_avg_frame_us, total_avg_fps_q8, history_count, zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW      = $clog2(HISTORY_DEPTH);
   localparam int FSUM_W  = FPS_W + CNT_W;
   localparam int USUM_W  = US_W + CNT_W;
   localparam int QDIV_W  = FPS_W + Q_FRAC_W;
   localparam int DIV_NW  = (FSUM_W > QDIV_W) ? FSUM_W : QDIV_W;
   localparam int DIV_DW  = FPS_W;
   localparam int WIN_W   = (CNT_W > AVGW_W) ? CNT_W : AVGW_W;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_FPS     = 8'b0000_0010,
      S_WIN     = 8'b0000_0100,
      S_DIV_WF  = 8'b0000_1000,
      S_DIV_WU  = 8'b0001_0000,
      S_DIV_TOT = 8'b0010_0000,
      S_DIV_Q   = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   cfg_type cfg;

   state_type           state_ff, state_in;
   logic [US_W-1:0]     us_ff, us_in;
   logic [FPS_W-1:0]    fps_ff, fps_in;
   logic                dropped_ff, dropped_in;
   logic [FPS_W-1:0]    drop_ff, drop_in;
   logic [QUAL_W-1:0]   quality_ff, quality_in;
   logic                qdiv_ff, qdiv_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FSUM_W-1:0]   total_ff, total_in;
   logic [FSUM_W-1:0]   wsum_fps_ff, wsum_fps_in;
   logic [USUM_W-1:0]   wsum_us_ff, wsum_us_in;
   logic [CNT_W-1:0]    win_ff, win_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    issue_left_ff, issue_left_in;
   logic                pend_ff, pend_in;
   logic                div_go_ff, div_go_in;
   logic [FPS_W-1:0]    wavg_fps_ff, wavg_fps_in;
   logic [US_W-1:0]     wavg_us_ff, wavg_us_in;
   logic [FPS_W-1:0]    tavg_ff, tavg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   logic [US_W-1:0]     us_eff;
   logic [FPS_W-1:0]    fps_new;
   logic                count_full;
   logic [CNT_W-1:0]    count_new;
   logic [AVGW_W-1:0]   avg_eff;
   logic [CNT_W-1:0]    win_new;
   logic [FSUM_W-1:0]   evict_fps;
   logic                dropped_new;
   logic [QUAL_W-1:0]   q_sum;

   logic                div_start;
   logic [DIV_NW-1:0]   div_dividend;
   logic [DIV_DW-1:0]   div_divisor;
   logic                div_done;
   logic [DIV_NW-1:0]   div_quotient;

   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   hist_entry_type      mem_wdata;
   hist_entry_type      mem_rdata;

   frmaq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   frmaq_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   frmaq_div #(
      .NW (DIV_NW),
      .DW (DIV_DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Handshake and frame-level values
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid & req_tready;
   assign us_eff      = (req_tdata == '0) ? US_W'(1) : req_tdata;
   assign fps_new     = div_quotient[FPS_W-1:0];
   assign count_full  = (count_ff == CNT_W'(HISTORY_DEPTH));
   assign count_new   = count_full ? count_ff : count_ff + 1'b1;
   assign avg_eff     = (cfg.avg_window == '0) ? AVGW_W'(1) : cfg.avg_window;
   assign win_new     = (WIN_W'(avg_eff) < WIN_W'(count_new)) ? CNT_W'(avg_eff) : count_new;
   assign evict_fps   = count_full ? FSUM_W'(mem_rdata.fps) : '0;
   assign dropped_new = (fps_new < cfg.min_fps);
   assign q_sum       = quality_ff + QUALITY_STEP;

   // Ring access: oldest entry on accept, then walk back from the newest
   assign mem_we        = (state_ff == S_FPS) && div_done;
   assign mem_wdata.fps = fps_new;
   assign mem_wdata.us  = us_ff;
   assign mem_re        = accept || ((state_ff == S_WIN) && (issue_left_ff != '0));
   assign mem_raddr     = (state_ff == S_IDLE) ? wp_ff : rd_ptr_ff;

   // Feed the shared divider
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_NW'(FPS_NUM);
      div_divisor  = DIV_DW'(us_eff);
      case (state_ff)
         S_IDLE: begin
            div_start = accept;
         end
         S_DIV_WF: begin
            div_start    = div_go_ff;
            div_dividend = DIV_NW'(wsum_fps_ff);
            div_divisor  = DIV_DW'(win_ff);
         end
         S_DIV_WU: begin
            div_start    = div_go_ff;
            div_dividend = DIV_NW'(wsum_us_ff);
            div_divisor  = DIV_DW'(win_ff);
         end
         S_DIV_TOT: begin
            div_start    = div_go_ff;
            div_dividend = DIV_NW'(total_ff);
            div_divisor  = DIV_DW'(count_ff);
         end
         S_DIV_Q: begin
            div_start    = div_go_ff;
            div_dividend = DIV_NW'(fps_ff) << Q_FRAC_W;
            div_divisor  = cfg.min_fps;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      us_in         = us_ff;
      fps_in        = fps_ff;
      dropped_in    = dropped_ff;
      drop_in       = drop_ff;
      quality_in    = quality_ff;
      qdiv_in       = qdiv_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      wsum_fps_in   = wsum_fps_ff;
      wsum_us_in    = wsum_us_ff;
      win_in        = win_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_left_in = issue_left_ff;
      pend_in       = pend_ff;
      div_go_in     = 1'b0;
      wavg_fps_in   = wavg_fps_ff;
      wavg_us_in    = wavg_us_ff;
      tavg_in       = tavg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // Drop the result word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               us_in    = us_eff;
               state_in = S_FPS;
            end
         end
         S_FPS: begin
            // Commit the frame: store, count, total, drop and quality
            if (div_done) begin
               fps_in      = fps_new;
               wp_in       = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               rd_ptr_in   = (wp_ff == '0) ? AW'(HISTORY_DEPTH - 1) : wp_ff - 1'b1;
               count_in    = count_new;
               total_in    = total_ff - evict_fps + FSUM_W'(fps_new);
               dropped_in  = dropped_new;
               drop_in     = dropped_new ? cfg.min_fps - fps_new : '0;
               qdiv_in     = dropped_new && cfg.adaptive;
               if (!dropped_new && cfg.adaptive && (quality_ff < QUALITY_FULL)) begin
                  quality_in = (q_sum > QUALITY_FULL) ? QUALITY_FULL : q_sum;
               end
               wsum_fps_in   = FSUM_W'(fps_new);
               wsum_us_in    = USUM_W'(us_ff);
               win_in        = win_new;
               issue_left_in = win_new - 1'b1;
               pend_in       = 1'b0;
               state_in      = S_WIN;
            end
         end
         S_WIN: begin
            // Issue one read a cycle, add what came back
            pend_in = 1'b0;
            if (issue_left_ff != '0) begin
               rd_ptr_in     = (rd_ptr_ff == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_ff - 1'b1;
               issue_left_in = issue_left_ff - 1'b1;
               pend_in       = 1'b1;
            end
            if (pend_ff) begin
               wsum_fps_in = wsum_fps_ff + FSUM_W'(mem_rdata.fps);
               wsum_us_in  = wsum_us_ff + USUM_W'(mem_rdata.us);
            end
            if ((issue_left_ff == '0) && !pend_ff) begin
               div_go_in = 1'b1;
               state_in  = S_DIV_WF;
            end
         end
         S_DIV_WF: begin
            if (div_done) begin
               wavg_fps_in = div_quotient[FPS_W-1:0];
               div_go_in   = 1'b1;
               state_in    = S_DIV_WU;
            end
         end
         S_DIV_WU: begin
            if (div_done) begin
               wavg_us_in = div_quotient[US_W-1:0];
               div_go_in  = 1'b1;
               state_in   = S_DIV_TOT;
            end
         end
         S_DIV_TOT: begin
            if (div_done) begin
               tavg_in = div_quotient[FPS_W-1:0];
               if (qdiv_ff) begin
                  div_go_in = 1'b1;
                  state_in  = S_DIV_Q;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_DIV_Q: begin
            if (div_done) begin
               quality_in = div_quotient[QUAL_W-1:0];
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            // Load the result word when the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {count_ff, tavg_ff, wavg_us_ff, wavg_fps_ff,
                               quality_ff, drop_ff, dropped_ff, fps_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         quality_ff    <= QUALITY_FULL;
         qdiv_ff       <= 1'b0;
         wp_ff         <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         issue_left_ff <= '0;
         pend_ff       <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         quality_ff    <= quality_in;
         qdiv_ff       <= qdiv_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         issue_left_ff <= issue_left_in;
         pend_ff       <= pend_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      us_ff       <= us_in;
      fps_ff      <= fps_in;
      dropped_ff  <= dropped_in;
      drop_ff     <= drop_in;
      wsum_fps_ff <= wsum_fps_in;
      wsum_us_ff  <= wsum_us_in;
      win_ff      <= win_in;
      rd_ptr_ff   <= rd_ptr_in;
      wavg_fps_ff <= wavg_fps_in;
      wavg_us_ff  <= wavg_us_in;
      tavg_ff     <= tavg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   `FRMAQ_ASSERT_IMP(a_quality_range, clock, reset, 1'b1, quality_ff <= QUALITY_FULL)
   `FRMAQ_ASSERT_IMP(a_win_bound, clock, reset, state_ff == S_WIN, (win_ff != '0) && (win_ff <= count_ff))
   `FRMAQ_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == S_FPS)
   `FRMAQ_ASSERT_IMP(a_div_quiet, clock, reset, state_ff == S_IDLE || state_ff == S_WIN || state_ff == S_OUT, !div_done)

endmodule

// ===== tb/frame_rate_monitor_adaptive_quality_top_tb.sv =====
// Self-checking testbench for the frame rate monitor with adaptive quality scale.
`timescale 1ns / 1ps

module frame_rate_monitor_adaptive_quality_top_tb;
   import frmaq_pkg::*;

   localparam int CNT_W       = $clog2(HISTORY_DEPTH_DEF + 1);
   localparam int RSP_W       = ((RSP_FIXED_W + CNT_W + 7) / 8) * 8;
   localparam int SCRIPT_LEN  = 27;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 106;
   localparam int IDLE_PCT    = 23;
   localparam int TAIL_CYCLES = 600;

   // One result word, fields from the top bit down so the packing matches rsp_tdata
   typedef struct packed {
      logic [CNT_W-1:0]  history_count;
      logic [FPS_W-1:0]  total_avg_fps;
      logic [US_W-1:0]   win_avg_us;
      logic [FPS_W-1:0]  win_avg_fps;
      logic [QUAL_W-1:0] quality;
      logic [FPS_W-1:0]  drop_amount;
      logic              dropped;
      logic [FPS_W-1:0]  fps;
   } frame_stats_type;

   localparam int STATS_W = $bits(frame_stats_type);

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      reg_index_type     reg_sel;
      logic [CSR_DW-1:0] value;
      logic [US_W-1:0]   us;
      logic              has_fps;
      logic [FPS_W-1:0]  fps;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [US_W-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Predictor copy of the configuration
   logic [FPS_W-1:0]  thr_q8     = MIN_FPS_RST;
   logic              adapt_on   = ADAPTIVE_RST;
   logic [AVGW_W-1:0] window_len = AVG_WINDOW_RST;

   // Predictor copy of the history ring and quality
   logic [FPS_W-1:0]  fps_ring [HISTORY_DEPTH_DEF];
   logic [US_W-1:0]   us_ring  [HISTORY_DEPTH_DEF];
   int                ring_wr    = 0;
   int                ring_held  = 0;
   logic [QUAL_W-1:0] quality_now = QUALITY_FULL;

   frame_stats_type pending_stats [$];
   int              mismatch_count = 0;
   logic            steady = 1'b0;

   // Directed words: extremes, drop and recovery, register special cases
   script_row_type script [SCRIPT_LEN] = '{
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd0,        1'b1, 28'd256000000},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd1,        1'b1, 28'd256000000},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'hFFFFFF,   1'b1, 28'd15},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd10000,    1'b1, 28'd25600},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd10001,    1'b1, 28'd25597},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd9999,     1'b1, 28'd25602},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd16666,    1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'hAAAAAA,   1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'h555555,   1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd256,      1'b1, 28'd1000000},
      '{ROW_CSR,   REG_ADAPTIVE,   32'd0,         24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd40000,    1'b1, 28'd6400},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd1000,     1'b1, 28'd256000},
      '{ROW_CSR,   REG_MIN_FPS,    32'd0,         24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'hFFFFFF,   1'b1, 28'd15},
      '{ROW_CSR,   REG_MIN_FPS,    32'h0FFFFFFF,  24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd0,        1'b1, 28'd256000000},
      '{ROW_CSR,   REG_ADAPTIVE,   32'd1,         24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd1,        1'b1, 28'd256000000},
      '{ROW_CSR,   REG_AVG_WINDOW, 32'd0,         24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd5000,     1'b1, 28'd51200},
      '{ROW_CSR,   REG_AVG_WINDOW, 32'd511,       24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd7,        1'b1, 28'd36571428},
      '{ROW_CSR,   REG_MIN_FPS,    32'd25600,     24'd0,        1'b0, 28'd0},
      '{ROW_CSR,   REG_AVG_WINDOW, 32'd1,         24'd0,        1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd123,      1'b0, 28'd0},
      '{ROW_FRAME, REG_MIN_FPS,    32'd0,         24'd3,        1'b1, 28'd85333333}
   };

   frame_rate_monitor_adaptive_quality_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // frame_us[23:0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // fps, dropped, drop amount, quality, window fps,
                                    // window frame time, total fps, count, zero pad
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Store one frame, update quality and compute the averages it reports
   function automatic frame_stats_type frame_stats(input logic [US_W-1:0] us_in);
      frame_stats_type   res;
      logic [US_W-1:0]   us;
      logic [31:0]       fps;
      logic [63:0]       win_fps_sum;
      logic [63:0]       win_us_sum;
      logic [63:0]       all_fps_sum;
      int                span;
      int                idx;
      us  = (us_in == '0) ? US_W'(1) : us_in;
      fps = 32'(FPS_NUM) / 32'(us);

      // Write the ring
      fps_ring[ring_wr] = fps[FPS_W-1:0];
      us_ring[ring_wr]  = us;
      ring_wr = (ring_wr + 1) % HISTORY_DEPTH_DEF;
      if (ring_held < HISTORY_DEPTH_DEF)
         ring_held++;

      // Drop check and quality scale
      res = '0;
      res.fps = fps[FPS_W-1:0];
      if (fps < 32'(thr_q8)) begin
         res.dropped = 1'b1;
         res.drop_amount = thr_q8 - fps[FPS_W-1:0];
         if (adapt_on)
            quality_now = QUAL_W'((64'(fps) << Q_FRAC_W) / 64'(thr_q8));
      end else if (adapt_on && quality_now < QUALITY_FULL) begin
         quality_now = quality_now + QUALITY_STEP;
         if (quality_now > QUALITY_FULL)
            quality_now = QUALITY_FULL;
      end
      res.quality = quality_now;

      // Walk from the newest entry back
      span = (window_len == '0) ? 1 : int'(window_len);
      if (span > ring_held)
         span = ring_held;
      win_fps_sum = '0;
      win_us_sum  = '0;
      all_fps_sum = '0;
      for (int age = 0; age < ring_held; age++) begin
         idx = (ring_wr + HISTORY_DEPTH_DEF - 1 - age) % HISTORY_DEPTH_DEF;
         if (age < span) begin
            win_fps_sum += 64'(fps_ring[idx]);
            win_us_sum  += 64'(us_ring[idx]);
         end
         all_fps_sum += 64'(fps_ring[idx]);
      end
      res.win_avg_fps   = FPS_W'(win_fps_sum / 64'(span));
      res.win_avg_us    = US_W'(win_us_sum / 64'(span));
      res.total_avg_fps = FPS_W'(all_fps_sum / 64'(ring_held));
      res.history_count = CNT_W'(ring_held);
      return res;
   endfunction

   // Frame times spread over typical rates, the threshold edge, and the extremes
   function automatic logic [US_W-1:0] pick_frame(input logic [FPS_W-1:0] thr);
      int unsigned roll;
      longint      edge_us;
      roll = $urandom_range(99);
      if (roll < 40)
         return US_W'($urandom_range(3000, 60000));
      if (roll < 65 && thr != '0) begin
         edge_us = longint'(FPS_NUM) / longint'(thr) + longint'($urandom_range(4)) - 2;
         if (edge_us < 0)
            edge_us = 0;
         if (edge_us > 64'hFFFFFF)
            edge_us = 64'hFFFFFF;
         return US_W'(edge_us);
      end
      if (roll < 80)
         return US_W'($urandom);
      if (roll < 90)
         return US_W'($urandom_range(0, 300));
      return US_W'($urandom_range(60000, 24'hFFFFFF));
   endfunction

   // One APB transfer; psel stays high so back-to-back transfers need no extra step
   task automatic csr_access(input logic wr, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] wdata, output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdata = csr_prdata;
         @(posedge clock);
      end while (!csr_pready);
   endtask

   // Write a register, mirror it in the predictor and read it back
   task automatic write_reg(input reg_index_type sel, input logic [CSR_DW-1:0] value);
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] readback;
      logic [CSR_DW-1:0] held;
      addr = {sel, 2'b00};
      case (sel)
         REG_MIN_FPS: begin
            thr_q8 = value[FPS_W-1:0];
            held = CSR_DW'(thr_q8);
         end
         REG_ADAPTIVE: begin
            adapt_on = value[0];
            held = CSR_DW'(adapt_on);
         end
         default: begin
            window_len = value[AVGW_W-1:0];
            held = CSR_DW'(window_len);
         end
      endcase
      csr_access(1'b1, addr, value, readback);
      csr_access(1'b0, addr, '0, readback);
      check_field("register readback", 64'(readback), 64'(held));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off the sender until every pending result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_stats.size() != 0)
         @(posedge clock);
   endtask

   // Offer one word after a random gap (none when steady); tvalid stays high on return
   task automatic send_frame(input logic [US_W-1:0] us, input logic has_fixed,
                             input logic [FPS_W-1:0] fixed_fps);
      frame_stats_type want;
      int              gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= us;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      want = frame_stats(us);
      if (has_fixed)
         want.fps = fixed_fps;
      pending_stats.insert(pending_stats.size(), want);
   endtask

   // Result side: random back-pressure (none when steady) and field-by-field check
   always @(posedge clock) begin : rsp_side
      frame_stats_type got;
      frame_stats_type want;
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[STATS_W-1:0];
         if (pending_stats.size() == 0) begin
            report_mismatch("result with none pending, fps", 64'(got.fps), 64'd0);
         end else begin
            want = pending_stats.pop_front();
            check_field("fps_q8", 64'(got.fps), 64'(want.fps));
            check_field("dropped", 64'(got.dropped), 64'(want.dropped));
            check_field("drop_amount_q8", 64'(got.drop_amount), 64'(want.drop_amount));
            check_field("quality_q16", 64'(got.quality), 64'(want.quality));
            check_field("window_avg_fps_q8", 64'(got.win_avg_fps), 64'(want.win_avg_fps));
            check_field("window_avg_frame_us", 64'(got.win_avg_us), 64'(want.win_avg_us));
            check_field("total_avg_fps_q8", 64'(got.total_avg_fps), 64'(want.total_avg_fps));
            check_field("history_count", 64'(got.history_count), 64'(want.history_count));
            check_field("pad bits", 64'(rsp_tdata[RSP_W-1:STATS_W]), 64'd0);
         end
      end
   end

   initial begin
      logic [FPS_W-1:0]  thr;
      logic              adapt;
      logic [AVGW_W-1:0] win;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(script[i].reg_sel, script[i].value);
         end else begin
            send_frame(script[i].us, script[i].has_fps, script[i].fps);
         end
      end

      // Random phases, each under its own settings
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin thr = FPS_W'(25600);     adapt = 1'b1; win = AVGW_W'(60);  end
            1: begin thr = FPS_NUM;           adapt = 1'b1; win = AVGW_W'(256); end
            2: begin thr = FPS_W'(1);         adapt = 1'b0; win = AVGW_W'(1);   end
            3: begin thr = '0;                adapt = 1'b1; win = '0;           end
            4: begin thr = '1;                adapt = 1'b1; win = '1;           end
            default: begin
               thr = $urandom_range(1) ? FPS_W'($urandom_range(2560, 76800))
                                       : FPS_W'($urandom_range(1, 256000000));
               adapt = 1'($urandom_range(1));
               win = AVGW_W'($urandom_range(0, 511));
            end
         endcase
         write_reg(REG_MIN_FPS, CSR_DW'(thr));
         write_reg(REG_ADAPTIVE, CSR_DW'(adapt));
         write_reg(REG_AVG_WINDOW, CSR_DW'(win));
         steady <= (phase == 5);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Pause mid-phase until the block has emptied
            if (phase == 6 && n == PHASE_WORDS / 2)
               wait_drained();
            send_frame(pick_frame(thr_q8), 1'b0, '0);
         end
      end

      // Drain, then watch for stray results
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
